>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the maze carver RTL.
// Every check samples on the rising edge of clk and is off while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every enabled clock edge.
`define MBC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be true.
`define MBC_ASSERT_NEVER(label, expr, msg) \
  `MBC_ASSERT(label, !(expr), msg)

`endif

>>> hdl/mbc_pkg.sv
// ----------------------------------------------------------------------------
// mbc_pkg
// Shared types and codes for the depth-first maze carver: commands, result
// events, directions, register indexes and the controller state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package mbc_pkg;

  // Field widths fixed by the channel formats
  localparam int SIZE_W    = 7;
  localparam int CFG_IDX_W = 2;
  localparam int WALL_W    = 8;
  localparam int DEPTH_W   = 13;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAZE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAZE_HEIGHT = 2'd1;

  // Commands
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // Result events
  typedef enum logic [1:0] {
    EV_START = 2'd0,
    EV_CARVE = 2'd1,
    EV_BACK  = 2'd2,
    EV_DONE  = 2'd3
  } event_t;

  // Directions, in the order of the unshuffled list
  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_t;

  // Controller states
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_STK  = 5'b00010,
    S_VIS  = 5'b00100,
    S_DEC  = 5'b01000,
    S_CLR  = 5'b10000
  } state_t;

  // Shuffle swap partners of one step
  typedef struct packed {
    logic [1:0] swap_pick3;
    logic [1:0] swap_pick2;
    logic       swap_pick1;
  } picks_t;

  // Outcome of the direction search
  typedef struct packed {
    logic found;
    dir_t dir;
  } sel_t;

endpackage

`default_nettype wire

>>> hdl/mbc_cmd_if.sv
// ----------------------------------------------------------------------------
// mbc_cmd_if
// Command channel: start or step command plus the three shuffle picks.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbc_cmd_if import mbc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       command;
  logic [1:0] swap_pick3;
  logic [1:0] swap_pick2;
  logic       swap_pick1;

  modport source (output valid, command, swap_pick3, swap_pick2, swap_pick1,
                  input ready);
  modport sink   (input valid, command, swap_pick3, swap_pick2, swap_pick1,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/mbc_res_if.sv
// ----------------------------------------------------------------------------
// mbc_res_if
// Result channel: event code, opened wall position and stack depth.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbc_res_if import mbc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         event_res;
  logic [WALL_W-1:0]  wall_row;
  logic [WALL_W-1:0]  wall_col;
  logic [DEPTH_W-1:0] depth;

  modport source (output valid, event_res, wall_row, wall_col, depth,
                  input ready);
  modport sink   (input valid, event_res, wall_row, wall_col, depth,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/mbc_dir_select.sv
// ----------------------------------------------------------------------------
// mbc_dir_select
// Fisher-Yates shuffle of the four directions from the supplied swap picks,
// then selection of the first shuffled direction that is open.
// ----------------------------------------------------------------------------
`default_nettype none

module mbc_dir_select import mbc_pkg::*; (
  input  picks_t     picks,
  input  logic [3:0] open_dirs,   // indexed by dir_t
  output sel_t       sel
);

  dir_t       order [4];
  dir_t       tmp;
  logic [1:0] p2;

  always_comb begin
    order = '{DIR_UP, DIR_RIGHT, DIR_DOWN, DIR_LEFT};
    // partner for position 2 saturates at 2
    p2 = (picks.swap_pick2 == 2'd3) ? 2'd2 : picks.swap_pick2;

    tmp = order[3];
    order[3] = order[picks.swap_pick3];
    order[picks.swap_pick3] = tmp;

    tmp = order[2];
    order[2] = order[p2];
    order[p2] = tmp;

    tmp = order[1];
    order[1] = order[{1'b0, picks.swap_pick1}];
    order[{1'b0, picks.swap_pick1}] = tmp;

    // first open direction wins: scan from the back so the earliest stays
    sel.found = 1'b0;
    sel.dir   = DIR_UP;
    for (int i = 3; i >= 0; i--) begin
      if (open_dirs[order[i]]) begin
        sel.found = 1'b1;
        sel.dir   = order[i];
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/maze_backtracker_carver_unit.sv
// ----------------------------------------------------------------------------
// maze_backtracker_carver_unit
// Randomized depth-first maze carver. Visited map is a row-wide memory, the
// path stack a second memory; each step reads, decides and writes back.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake        contents
//   cmd      in   valid / ready    command, swap_pick3, swap_pick2, swap_pick1
//   res      out  valid / ready    event_res, wall_row, wall_col, depth
//   cfg      in   cfg_wr_en        cfg_index, cfg_data (maze_width, maze_height)
//
// A step goes through accept and stack read, the visited-row reads of S_STK and S_VIS on
// the dual-read visited memory, then decide and write back in S_DEC.
// A start sweeps all 2**clog2(MAX_SIDE) rows of the visited memory one row a cycle
// (64 rows at MAX_SIDE = 64).
// Synchronous active-high reset clears the control state; memories are not
// reset. A new command is taken while a result waits in the output register;
// the next result stalls in its final cycle until that register is free.
//
`default_nettype none

module maze_backtracker_carver_unit import mbc_pkg::*; #(
  parameter int MAX_SIDE = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SIZE_W-1:0]    cfg_data,
  mbc_cmd_if.sink                   cmd,
  mbc_res_if.source                 res
);

  `include "assert_macros.svh"

  localparam int CW     = $clog2(MAX_SIDE);
  localparam int ROWS   = 2 ** CW;
  localparam int CELLS  = MAX_SIDE * MAX_SIDE;
  localparam int IDX_W  = $clog2(CELLS);
  localparam int TOP_W  = $clog2(CELLS + 1);
  localparam int SW     = $clog2(MAX_SIDE + 1);
  localparam int CMP_W  = (SW > SIZE_W) ? SW : SIZE_W;
  localparam int WSUM_W = CW + 2;
  localparam logic [CW-1:0] LAST_ROW = CW'(ROWS - 1);

  // Registers
  state_t             state, state_next;
  logic [TOP_W-1:0]   stack_top, top_next;
  logic [SIZE_W-1:0]  width_reg, height_reg;
  logic [CW-1:0]      clr_row, clr_row_next;
  picks_t             picks;
  logic [CW-1:0]      cr, cc;
  logic [ROWS-1:0]    cur_row, up_row;
  logic               res_valid;
  event_t             res_event;
  logic [WALL_W-1:0]  res_wall_row, res_wall_col;
  logic [DEPTH_W-1:0] res_depth;

  // Memories
  logic [2*CW-1:0]    stack_mem [CELLS];
  logic [ROWS-1:0]    vis_mem   [ROWS];
  logic [2*CW-1:0]    stk_rd_data;
  logic [ROWS-1:0]    vis_rd_a, vis_rd_b;

  // Memory controls
  logic               stk_rd_en;
  logic [IDX_W-1:0]   stk_rd_addr;
  logic               stk_we;
  logic [IDX_W-1:0]   stk_wr_addr;
  logic [2*CW-1:0]    stk_wr_data;
  logic               vis_rd_en_a, vis_rd_en_b;
  logic [CW-1:0]      vis_addr_a, vis_addr_b;
  logic               vis_we;
  logic [CW-1:0]      vis_wr_addr;
  logic [ROWS-1:0]    vis_wr_data;

  // Step datapath
  logic               cmd_xfer, res_free, res_load;
  logic [CMP_W-1:0]   wid_ext, hgt_ext;
  logic [SW-1:0]      w, h;
  logic [SW-1:0]      cr_ext, cc_ext;
  logic [CW-1:0]      cr_inc, cr_dec, cc_inc, cc_dec;
  logic [CW-1:0]      stk_row, stk_col;
  logic [3:0]         open_dirs;
  sel_t               sel;
  logic [CW-1:0]      nr, nc;
  logic [ROWS-1:0]    src_row;
  logic [WSUM_W-1:0]  wall_r_sum, wall_c_sum;
  logic               stack_empty, stack_full;
  event_t             ev_next;
  logic [WALL_W-1:0]  wall_row_next, wall_col_next;

  assign cmd_xfer  = cmd.valid && cmd.ready;
  assign cmd.ready = (state == S_IDLE);
  assign res_free  = !res_valid || res.ready;

  // Clamp the size registers to [2, MAX_SIDE]
  assign wid_ext = CMP_W'(width_reg);
  assign hgt_ext = CMP_W'(height_reg);
  assign w = (wid_ext < CMP_W'(2)) ? SW'(2) :
             (wid_ext > CMP_W'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(wid_ext);
  assign h = (hgt_ext < CMP_W'(2)) ? SW'(2) :
             (hgt_ext > CMP_W'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(hgt_ext);

  // Current cell and its neighbours
  assign stk_row = stk_rd_data[2*CW-1:CW];
  assign stk_col = stk_rd_data[CW-1:0];
  assign cr_ext  = SW'(cr);
  assign cc_ext  = SW'(cc);
  assign cr_inc  = cr + CW'(1);
  assign cr_dec  = cr - CW'(1);
  assign cc_inc  = cc + CW'(1);
  assign cc_dec  = cc - CW'(1);

  // Neighbour open: inside the current grid and not yet visited.
  // Down row comes straight from read port A in the decide cycle.
  assign open_dirs[DIR_UP]    = (cr != '0) && (cr_ext <= h) && (cc_ext < w) &&
                                !up_row[cc];
  assign open_dirs[DIR_RIGHT] = (cc_ext + SW'(1) < w) && (cr_ext < h) &&
                                !cur_row[cc_inc];
  assign open_dirs[DIR_DOWN]  = (cr_ext + SW'(1) < h) && (cc_ext < w) &&
                                !vis_rd_a[cc];
  assign open_dirs[DIR_LEFT]  = (cc != '0) && (cc_ext <= w) && (cr_ext < h) &&
                                !cur_row[cc_dec];

  mbc_dir_select u_dir_select (
    .picks     (picks),
    .open_dirs (open_dirs),
    .sel       (sel)
  );

  // Chosen neighbour and the row word that holds its visited bit
  always_comb begin
    unique case (sel.dir)
      DIR_UP: begin
        nr = cr_dec; nc = cc; src_row = up_row;
      end
      DIR_RIGHT: begin
        nr = cr; nc = cc_inc; src_row = cur_row;
      end
      DIR_DOWN: begin
        nr = cr_inc; nc = cc; src_row = vis_rd_a;
      end
      DIR_LEFT: begin
        nr = cr; nc = cc_dec; src_row = cur_row;
      end
      default: begin
        nr = cr; nc = cc; src_row = cur_row;
      end
    endcase
  end

  assign wall_r_sum  = WSUM_W'(cr) + WSUM_W'(nr) + WSUM_W'(1);
  assign wall_c_sum  = WSUM_W'(cc) + WSUM_W'(nc) + WSUM_W'(1);
  assign stack_empty = (stack_top == '0);
  assign stack_full  = (stack_top >= TOP_W'(CELLS));

  // Controller and memory port control
  always_comb begin
    state_next    = state;
    top_next      = stack_top;
    clr_row_next  = clr_row;
    stk_rd_en     = 1'b0;
    stk_rd_addr   = stack_top[IDX_W-1:0] - IDX_W'(1);
    stk_we        = 1'b0;
    stk_wr_addr   = stack_top[IDX_W-1:0];
    stk_wr_data   = {nr, nc};
    vis_rd_en_a   = 1'b0;
    vis_rd_en_b   = 1'b0;
    vis_addr_a    = cr_inc;
    vis_addr_b    = stk_row - CW'(1);
    vis_we        = 1'b0;
    vis_wr_addr   = nr;
    vis_wr_data   = src_row | (ROWS'(1) << nc);
    res_load      = 1'b0;
    ev_next       = EV_DONE;
    wall_row_next = '0;
    wall_col_next = '0;

    unique case (state)
      S_IDLE: begin
        if (cmd_xfer) begin
          stk_rd_en = 1'b1;
          if (cmd.command == CMD_START) begin
            clr_row_next = '0;
            state_next   = S_CLR;
          end else begin
            state_next = S_STK;
          end
        end
      end

      // stack top arrived: fetch current row and the row above
      S_STK: begin
        vis_rd_en_a = 1'b1;
        vis_addr_a  = stk_row;
        vis_rd_en_b = 1'b1;
        state_next  = S_VIS;
      end

      // current and upper rows arrived: fetch the row below
      S_VIS: begin
        vis_rd_en_a = 1'b1;
        vis_addr_a  = cr_inc;
        state_next  = S_DEC;
      end

      // decide, write back, load the result
      S_DEC: begin
        if (res_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
          priority if (stack_empty) begin
            ev_next  = EV_DONE;
            top_next = '0;
          end else if (sel.found && !stack_full) begin
            ev_next       = EV_CARVE;
            vis_we        = 1'b1;
            stk_we        = 1'b1;
            top_next      = stack_top + TOP_W'(1);
            wall_row_next = WALL_W'(wall_r_sum);
            wall_col_next = WALL_W'(wall_c_sum);
          end else if (sel.found) begin
            ev_next = EV_BACK;
          end else begin
            ev_next  = EV_BACK;
            top_next = stack_top - TOP_W'(1);
          end
        end
      end

      // clear one visited row per cycle; row 0 gets the start cell
      S_CLR: begin
        vis_we      = 1'b1;
        vis_wr_addr = clr_row;
        vis_wr_data = (clr_row == '0) ? ROWS'(1) : '0;
        stk_we      = 1'b1;
        stk_wr_addr = '0;
        stk_wr_data = '0;
        if (clr_row != LAST_ROW) begin
          clr_row_next = clr_row + CW'(1);
        end else if (res_free) begin
          res_load   = 1'b1;
          ev_next    = EV_START;
          top_next   = TOP_W'(1);
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      stack_top  <= '0;
      width_reg  <= SIZE_W'(2);
      height_reg <= SIZE_W'(2);
      clr_row    <= '0;
      res_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      stack_top <= top_next;
      clr_row   <= clr_row_next;
      if (cfg_wr_en && (cfg_index == CFG_MAZE_WIDTH)) begin
        width_reg <= cfg_data;
      end
      if (cfg_wr_en && (cfg_index == CFG_MAZE_HEIGHT)) begin
        height_reg <= cfg_data;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd_xfer) begin
      picks <= '{swap_pick3: cmd.swap_pick3, swap_pick2: cmd.swap_pick2,
                 swap_pick1: cmd.swap_pick1};
    end
    if (state == S_STK) begin
      cr <= stk_row;
      cc <= stk_col;
    end
    if (state == S_VIS) begin
      cur_row <= vis_rd_a;
      up_row  <= vis_rd_b;
    end
    if (res_load) begin
      res_event    <= ev_next;
      res_wall_row <= wall_row_next;
      res_wall_col <= wall_col_next;
      res_depth    <= DEPTH_W'(top_next);
    end
  end

  // Path stack memory
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_wr_addr] <= stk_wr_data;
    end
    if (stk_rd_en) begin
      stk_rd_data <= stack_mem[stk_rd_addr];
    end
  end

  // Visited map memory, one row per word, two read ports
  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_wr_addr] <= vis_wr_data;
    end
    if (vis_rd_en_a) begin
      vis_rd_a <= vis_mem[vis_addr_a];
    end
    if (vis_rd_en_b) begin
      vis_rd_b <= vis_mem[vis_addr_b];
    end
  end

  assign res.valid     = res_valid;
  assign res.event_res = res_event;
  assign res.wall_row  = res_wall_row;
  assign res.wall_col  = res_wall_col;
  assign res.depth     = res_depth;

  // Checks
  `MBC_ASSERT(a_top_bound, stack_top <= TOP_W'(CELLS), "stack depth beyond cell count")
  `MBC_ASSERT_NEVER(a_no_overwrite, res_load && res_valid && !res.ready, "result overwritten")
  `MBC_ASSERT(a_carve_push, (res_load && ev_next == EV_CARVE) |=> (stack_top == $past(stack_top) + TOP_W'(1)), "carve did not push")
  `MBC_ASSERT(a_clear_quiet, (state == S_CLR && clr_row != LAST_ROW) |-> !res_load, "result during clear")

endmodule

`default_nettype wire

>>> tb/tb_maze_backtracker_carver_unit.sv
// ----------------------------------------------------------------------------
// tb_maze_backtracker_carver_unit
// Self-checking bench for the depth-first maze carver. A short table of
// start/step commands runs first, then phases of mostly well-formed carving
// runs with random swap picks. Between phases the maze size is rewritten,
// sometimes mid-maze. Every result transfer is checked against the table's
// expected result or an in-bench maze tracker with its own visited map and path stack.
// ----------------------------------------------------------------------------

module tb_maze_backtracker_carver_unit import mbc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAZE_SIDE     = 64;
  localparam int CELLS         = MAZE_SIDE * MAZE_SIDE;
  localparam int SETTLE_CYCLES = 80;      // covers a start sweep plus a step
  localparam int LIMIT_CYCLES  = 600000;
  localparam int DIRECTED_N    = 15;
  localparam int RANDOM_ITEMS  = 1000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;  // not a register

  typedef struct packed {
    logic       command;
    logic [1:0] swap_pick3;
    logic [1:0] swap_pick2;
    logic       swap_pick1;
  } carve_cmd_t;

  typedef struct packed {
    event_t             ev;
    logic [WALL_W-1:0]  wall_row;
    logic [WALL_W-1:0]  wall_col;
    logic [DEPTH_W-1:0] depth;
  } carve_out_t;

  typedef struct packed {
    carve_cmd_t cmd;
    logic       typed;
    carve_out_t want;
  } step_row_t;

  localparam carve_out_t NO_OUT = '0;

  logic                 clk;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]    cfg_data;

  mbc_cmd_if cmd_if ();
  mbc_res_if res_if ();

  maze_backtracker_carver_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_if),
    .res       (res_if)
  );

  // Maze tracker state
  logic               seen_map [CELLS];
  logic [11:0]        trail [CELLS];
  int unsigned        trail_len;
  logic [SIZE_W-1:0]  width_reg;
  logic [SIZE_W-1:0]  height_reg;
  carve_out_t         outcome_q [$];

  // Run bookkeeping
  int          send_idle_pct;
  int          recv_stall_pct;
  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned commands_sent;
  int unsigned phase_count;
  int unsigned ev_count [4];
  int unsigned deepest;
  int unsigned far_row;
  int unsigned far_col;
  carve_out_t  got_want;
  step_row_t   directed_rows [DIRECTED_N];

  // Clock
  always #10 clk = ~clk;

  function automatic int clamp_side(logic [SIZE_W-1:0] v);
    if (v < 2) return 2;
    if (v > MAZE_SIDE) return MAZE_SIDE;
    return int'(v);
  endfunction

  // Apply one command to the tracker and return the result it must produce
  function automatic carve_out_t advance_maze(carve_cmd_t c);
    carve_out_t o;
    dir_t       order [4];
    dir_t       tmp;
    dir_t       d;
    logic [1:0] p2;
    int         w, h, cur_r, cur_c, nr, nc, idx;
    bit         found;
    o = NO_OUT;
    w = clamp_side(width_reg);
    h = clamp_side(height_reg);
    found = 1'b0;

    if (c.command == CMD_START) begin
      foreach (seen_map[i]) seen_map[i] = 1'b0;
      trail[0] = '0;
      seen_map[0] = 1'b1;
      trail_len = 1;
      o.ev = EV_START;
      o.depth = DEPTH_W'(1);
      return o;
    end
    if (trail_len == 0) begin
      o.ev = EV_DONE;
      return o;
    end

    cur_r = int'(trail[trail_len-1]) / MAZE_SIDE;
    cur_c = int'(trail[trail_len-1]) % MAZE_SIDE;

    // Fisher-Yates shuffle driven by the supplied picks
    order[0] = DIR_UP;
    order[1] = DIR_RIGHT;
    order[2] = DIR_DOWN;
    order[3] = DIR_LEFT;
    p2 = (c.swap_pick2 > 2'd2) ? 2'd2 : c.swap_pick2;
    tmp = order[3]; order[3] = order[c.swap_pick3]; order[c.swap_pick3] = tmp;
    tmp = order[2]; order[2] = order[p2];           order[p2] = tmp;
    tmp = order[1]; order[1] = order[c.swap_pick1]; order[c.swap_pick1] = tmp;

    // First in-grid, unvisited neighbour wins
    for (int k = 0; k < 4; k++) begin
      if (!found) begin
        d = order[k];
        nr = cur_r;
        nc = cur_c;
        case (d)
          DIR_UP:    nr = cur_r - 1;
          DIR_RIGHT: nc = cur_c + 1;
          DIR_DOWN:  nr = cur_r + 1;
          default:   nc = cur_c - 1;
        endcase
        if (nr >= 0 && nr < h && nc >= 0 && nc < w) begin
          idx = nr * MAZE_SIDE + nc;
          if (!seen_map[idx]) begin
            found = 1'b1;
            if (trail_len >= CELLS) begin
              o.ev = EV_BACK;
              o.depth = DEPTH_W'(trail_len);
            end else begin
              seen_map[idx] = 1'b1;
              trail[trail_len] = 12'(idx);
              trail_len++;
              o.ev = EV_CARVE;
              o.wall_row = WALL_W'(cur_r + nr + 1);
              o.wall_col = WALL_W'(cur_c + nc + 1);
              o.depth = DEPTH_W'(trail_len);
            end
          end
        end
      end
    end

    if (!found) begin
      trail_len--;
      o.ev = EV_BACK;
      o.depth = DEPTH_W'(trail_len);
    end
    return o;
  endfunction

  task automatic note_fail(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Drive one command; on transfer record what it must produce
  task automatic send_cmd(input carve_cmd_t c, input bit typed, input carve_out_t want);
    carve_out_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.command    <= c.command;
    cmd_if.swap_pick3 <= c.swap_pick3;
    cmd_if.swap_pick2 <= c.swap_pick2;
    cmd_if.swap_pick1 <= c.swap_pick1;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    predicted = advance_maze(c);
    outcome_q.push_back(typed ? want : predicted);
    commands_sent++;
    @(negedge clk);
  endtask

  // Stop sending until every pending result has come back
  task automatic hold_until_drained();
    cmd_if.valid <= 1'b0;
    @(negedge clk);
    while (outcome_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == CFG_MAZE_WIDTH) width_reg = val;
    else if (idx == CFG_MAZE_HEIGHT) height_reg = val;
    @(negedge clk);
  endtask

  // One phase: resize while idle, then a run of carving commands
  task automatic run_phase(input logic [SIZE_W-1:0] w_val, input logic [SIZE_W-1:0] h_val,
                           input int n, input bit restart, input bit walk_right);
    carve_cmd_t c;
    int         mode;
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(CFG_MAZE_WIDTH, w_val);
    write_reg(CFG_MAZE_HEIGHT, h_val);
    if ($urandom_range(2) == 0) write_reg(CFG_SPARE_IDX, SIZE_W'($urandom_range(127)));
    cfg_wr_en <= 1'b0;

    mode = phase_count % 4;
    phase_count++;
    send_idle_pct  = (mode == 1) ? 79 : (mode == 3) ? 26 : 0;
    recv_stall_pct = (mode == 2) ? 79 : (mode == 3) ? 26 : 0;

    c = '0;
    if (restart) begin
      c.command = CMD_START;
      send_cmd(c, 1'b0, NO_OUT);
    end
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(63) == 0) hold_until_drained();
      c.swap_pick3 = 2'($urandom_range(3));
      c.swap_pick2 = 2'($urandom_range(3));
      c.swap_pick1 = 1'($urandom_range(1));
      // right-first order walks row 0 then down the last column
      if (walk_right && $urandom_range(99) < 90) begin
        c.swap_pick3 = 2'd3;
        c.swap_pick2 = 2'd2;
        c.swap_pick1 = 1'b0;
      end
      if (trail_len == 0)
        c.command = ($urandom_range(99) < 80) ? CMD_START : CMD_STEP;
      else
        c.command = (!walk_right && $urandom_range(99) < 2) ? CMD_START : CMD_STEP;
      send_cmd(c, 1'b0, NO_OUT);
    end
  endtask

  // Receiver back-pressure
  always @(negedge clk) begin
    res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      if (outcome_q.size() == 0) begin
        note_fail($sformatf("result ev=%0d row=%0d col=%0d depth=%0d with nothing pending",
                            res_if.event_res, res_if.wall_row, res_if.wall_col,
                            res_if.depth));
      end else begin
        got_want = outcome_q.pop_front();
        if (res_if.event_res !== got_want.ev || res_if.wall_row !== got_want.wall_row ||
            res_if.wall_col !== got_want.wall_col || res_if.depth !== got_want.depth)
          note_fail($sformatf({"exp ev=%0d row=%0d col=%0d depth=%0d, ",
                               "got ev=%0d row=%0d col=%0d depth=%0d"},
                              got_want.ev, got_want.wall_row, got_want.wall_col,
                              got_want.depth, res_if.event_res, res_if.wall_row,
                              res_if.wall_col, res_if.depth));
      end
      ev_count[res_if.event_res]++;
      if (int'(res_if.depth) > deepest) deepest = int'(res_if.depth);
      if (int'(res_if.wall_row) > far_row) far_row = int'(res_if.wall_row);
      if (int'(res_if.wall_col) > far_col) far_col = int'(res_if.wall_col);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_count, outcome_q.size());
      $display("** maze_backtracker_carver_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    int          sel;
    logic [6:0]  w_pick;
    logic [6:0]  h_pick;
    clk = 1'b0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    cmd_if.valid      = 1'b0;
    cmd_if.command    = 1'b0;
    cmd_if.swap_pick3 = '0;
    cmd_if.swap_pick2 = '0;
    cmd_if.swap_pick1 = 1'b0;
    res_if.ready = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cycle_count = 0;
    fail_count = 0;
    commands_sent = 0;
    phase_count = 0;
    deepest = 0;
    far_row = 0;
    far_col = 0;
    foreach (ev_count[i]) ev_count[i] = 0;

    // tracker reset state
    foreach (seen_map[i]) seen_map[i] = 1'b0;
    trail_len  = 0;
    width_reg  = 7'd2;
    height_reg = 7'd2;

    // Directed table on the 2x2 reset size
    directed_rows[0]  = '{'{CMD_STEP,  2'd0, 2'd0, 1'b0}, 1'b1, '{EV_DONE,  8'd0, 8'd0, 13'd0}};
    directed_rows[1]  = '{'{CMD_START, 2'd3, 2'd3, 1'b1}, 1'b1, '{EV_START, 8'd0, 8'd0, 13'd1}};
    directed_rows[2]  = '{'{CMD_STEP,  2'd3, 2'd2, 1'b0}, 1'b0, NO_OUT};
    directed_rows[3]  = '{'{CMD_STEP,  2'd0, 2'd3, 1'b1}, 1'b0, NO_OUT};
    // restart in the middle of a maze
    directed_rows[4]  = '{'{CMD_START, 2'd0, 2'd0, 1'b0}, 1'b1, '{EV_START, 8'd0, 8'd0, 13'd1}};
    directed_rows[5]  = '{'{CMD_STEP,  2'd1, 2'd0, 1'b1}, 1'b0, NO_OUT};
    directed_rows[6]  = '{'{CMD_STEP,  2'd2, 2'd1, 1'b0}, 1'b0, NO_OUT};
    directed_rows[7]  = '{'{CMD_STEP,  2'd3, 2'd3, 1'b1}, 1'b0, NO_OUT};
    directed_rows[8]  = '{'{CMD_STEP,  2'd0, 2'd2, 1'b0}, 1'b0, NO_OUT};
    directed_rows[9]  = '{'{CMD_STEP,  2'd1, 2'd1, 1'b1}, 1'b0, NO_OUT};
    directed_rows[10] = '{'{CMD_STEP,  2'd2, 2'd0, 1'b0}, 1'b0, NO_OUT};
    // 2x2 maze: three carves and four pops, the last pop empties the stack
    directed_rows[11] = '{'{CMD_STEP,  2'd3, 2'd1, 1'b1}, 1'b1, '{EV_BACK,  8'd0, 8'd0, 13'd0}};
    directed_rows[12] = '{'{CMD_STEP,  2'd0, 2'd1, 1'b0}, 1'b1, '{EV_DONE,  8'd0, 8'd0, 13'd0}};
    directed_rows[13] = '{'{CMD_STEP,  2'd3, 2'd3, 1'b1}, 1'b1, '{EV_DONE,  8'd0, 8'd0, 13'd0}};
    directed_rows[14] = '{'{CMD_START, 2'd2, 2'd2, 1'b1}, 1'b1, '{EV_START, 8'd0, 8'd0, 13'd1}};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIRECTED_N; r++)
      send_cmd(directed_rows[r].cmd, directed_rows[r].typed, directed_rows[r].want);

    // Fixed phases: size clamps, the full 64x64 corner walk, shrinking mid-maze
    run_phase(7'd0,   7'd1,  60, 1'b1, 1'b0);
    run_phase(7'd3,   7'd3,  80, 1'b1, 1'b0);
    run_phase(7'd127, 7'd64, 220, 1'b1, 1'b1);
    run_phase(7'd5,   7'd4,  90, 1'b0, 1'b0);
    run_phase(7'd64,  7'd2,  60, 1'b1, 1'b0);
    run_phase(7'd2,   7'd64, 60, 1'b1, 1'b0);
    run_phase(7'd2,   7'd2,  40, 1'b0, 1'b0);

    // Random phases, mostly small mazes run to completion
    while (commands_sent < DIRECTED_N + RANDOM_ITEMS) begin
      sel = $urandom_range(9);
      w_pick = (sel < 7) ? SIZE_W'($urandom_range(2, 8)) :
               (sel < 9) ? SIZE_W'($urandom_range(9, 64)) : SIZE_W'($urandom_range(0, 127));
      sel = $urandom_range(9);
      h_pick = (sel < 7) ? SIZE_W'($urandom_range(2, 8)) :
               (sel < 9) ? SIZE_W'($urandom_range(9, 64)) : SIZE_W'($urandom_range(0, 127));
      run_phase(w_pick, h_pick, $urandom_range(40, 90), $urandom_range(3) != 0, 1'b0);
    end

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Ran %0d commands in %0d size phases: %0d starts, %0d carves,",
             commands_sent, phase_count, ev_count[EV_START], ev_count[EV_CARVE]);
    $display("%0d backtracks, %0d finished, deepest stack %0d, farthest wall %0d / %0d",
             ev_count[EV_BACK], ev_count[EV_DONE], deepest, far_row, far_col);
    if (fail_count == 0)
      $display("** maze_backtracker_carver_unit: PASSED **");
    else
      $display("** maze_backtracker_carver_unit: FAILED **");
    $finish;
  end

endmodule
